/* hdl/prr_arm_forward_kinematics_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the arm forward kinematics block
// Shared property forms, clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef PRR_ARM_FORWARD_KINEMATICS_MACROS_SVH
`define PRR_ARM_FORWARD_KINEMATICS_MACROS_SVH

// same-cycle implication
`define PRR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define PRR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hdl/prr_fk_pkg.sv */
// ---------------------------------------------------------------------------
// prr_fk_pkg
// Fixed widths, command codes, register map and CORDIC constants.
// ---------------------------------------------------------------------------
package prr_fk_pkg;

  localparam int ANG_W  = 13;
  localparam int AMT_W  = 12;
  localparam int LEN_W  = 14;
  localparam int CMD_W  = 2;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int REG_W  = 2;

  localparam logic [CMD_W-1:0] CMD_SLIDE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SHOULDER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRIST    = 2'd2;

  localparam logic [REG_W-1:0] REG_LINK1    = 2'd0;
  localparam logic [REG_W-1:0] REG_LINK2    = 2'd1;
  localparam logic [REG_W-1:0] REG_SHOULDER = 2'd2;

  localparam logic [ANG_W-1:0] FULL_TURN    = 13'd5760;
  localparam logic [ANG_W-1:0] QUARTER_TURN = 13'd1440;
  localparam logic [ANG_W-1:0] HALF_TURN    = 13'd2880;
  localparam logic [ANG_W-1:0] THREE_QUARTER_TURN = 13'd4320;

  localparam logic [LEN_W-1:0] LINK1_RST    = 14'd1600;
  localparam logic [LEN_W-1:0] LINK2_RST    = 14'd1200;
  localparam logic [LEN_W-1:0] SHOULDER_RST = 14'd2400;

  // CORDIC datapath
  localparam int GAIN_W  = 30;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
  localparam int PROD_W  = LEN_W + GAIN_W;
  localparam int XY_W    = 32;
  localparam int Z_W     = 30;
  localparam int TRIG_W  = 18;
  localparam int ATAN_N  = 24;
  localparam int ATAN_IDX_W = 5;
  localparam int ATAN_W  = 26;

  localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_N] = '{
    26'd47185920, 26'd27855475, 26'd14718068, 26'd7471121, 26'd3750058, 26'd1876857,
    26'd938658,   26'd469357,   26'd234682,   26'd117342,  26'd58671,   26'd29335,
    26'd14668,    26'd7334,     26'd3667,     26'd1833,    26'd917,     26'd458,
    26'd229,      26'd115,      26'd57,       26'd29,      26'd14,      26'd7
  };

  typedef struct packed {
    logic [LEN_W-1:0] link1;
    logic [LEN_W-1:0] link2;
    logic [LEN_W-1:0] shoulder;
  } cfg_t;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] cos;
    logic signed [TRIG_W-1:0] sin;
  } trig_t;

endpackage

/* hdl/prr_fk_if.sv */
// ---------------------------------------------------------------------------
// prr_fk_if
// Valid/ready channels for jog commands and pose results.
// ---------------------------------------------------------------------------
interface prr_fk_jog_if import prr_fk_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [AMT_W-1:0] amount;

  modport source (output valid, output cmd, output amount, input ready);
  modport sink   (input valid, input cmd, input amount, output ready);
endinterface

interface prr_fk_pose_if import prr_fk_pkg::*; #(parameter int POS_WIDTH = 20);
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] base_pos_x;
  logic [ANG_W-1:0]            shoulder_angle;
  logic [ANG_W-1:0]            link2_angle;
  logic signed [POS_WIDTH-1:0] elbow_x;
  logic signed [POS_WIDTH-1:0] elbow_y;
  logic signed [POS_WIDTH-1:0] brush_x;
  logic signed [POS_WIDTH-1:0] brush_y;

  modport source (output valid, output base_pos_x, output shoulder_angle,
                  output link2_angle, output elbow_x, output elbow_y,
                  output brush_x, output brush_y, input ready);
  modport sink   (input valid, input base_pos_x, input shoulder_angle,
                  input link2_angle, input elbow_x, input elbow_y,
                  input brush_x, input brush_y, output ready);
endinterface

/* hdl/prr_fk_apb.sv */
// ---------------------------------------------------------------------------
// prr_fk_apb
// APB register file for link lengths and shoulder height.
// ---------------------------------------------------------------------------
module prr_fk_apb import prr_fk_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t             cfg_q;
  logic             wr_en;
  logic [REG_W-1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.link1    <= LINK1_RST;
      cfg_q.link2    <= LINK2_RST;
      cfg_q.shoulder <= SHOULDER_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_LINK1:    cfg_q.link1    <= pwdata[LEN_W-1:0];
        REG_LINK2:    cfg_q.link2    <= pwdata[LEN_W-1:0];
        REG_SHOULDER: cfg_q.shoulder <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LINK1:    prdata = DATA_W'(cfg_q.link1);
      REG_LINK2:    prdata = DATA_W'(cfg_q.link2);
      REG_SHOULDER: prdata = DATA_W'(cfg_q.shoulder);
      default:      prdata = '0;
    endcase
  end

endmodule

/* hdl/prr_fk_cordic.sv */
// ---------------------------------------------------------------------------
// prr_fk_cordic
// Iterative rotation CORDIC: one micro-rotation per cycle, gives len*cos
// and len*sin rounded to whole units of len_i.
// ---------------------------------------------------------------------------
module prr_fk_cordic import prr_fk_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [LEN_W-1:0] len_i,
  input  logic [ANG_W-1:0] ang_i,
  output trig_t            res_o
);

  localparam int IT_W  = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
  localparam int RND_W = XY_W + 1 - 16;

  typedef enum logic [1:0] {C_IDLE, C_LOAD, C_ITER, C_ROUND} cstate_e;

  cstate_e                  state_q;
  logic [PROD_W-1:0]        prod_q;
  logic signed [XY_W-1:0]   x_q, y_q;
  logic signed [Z_W-1:0]    z_q;
  logic                     flip_q;
  logic [IT_W-1:0]          it_q;
  logic                     done_q;
  logic signed [TRIG_W-1:0] cos_q, sin_q;

  logic signed [ANG_W:0]    a_fold;
  logic                     flip_d;
  logic signed [XY_W-1:0]   dx, dy;
  logic signed [Z_W-1:0]    at;
  logic signed [XY_W:0]     xr, yr;
  logic signed [RND_W-1:0]  rc, rs;

  always_comb begin
    a_fold = $signed({1'b0, ang_i});
    flip_d = 1'b0;
    if (ang_i >= THREE_QUARTER_TURN) begin
      a_fold = a_fold - $signed({1'b0, FULL_TURN});
    end else if (ang_i > QUARTER_TURN) begin
      a_fold = a_fold - $signed({1'b0, HALF_TURN});
      flip_d = 1'b1;
    end
  end

  assign dx = y_q >>> it_q;
  assign dy = x_q >>> it_q;
  assign at = $signed(Z_W'(ATAN_TAB[ATAN_IDX_W'(it_q)]));
  assign xr = $signed({x_q[XY_W-1], x_q}) + $signed((XY_W+1)'(32768));
  assign yr = $signed({y_q[XY_W-1], y_q}) + $signed((XY_W+1)'(32768));
  assign rc = $signed(xr[XY_W:16]);
  assign rs = $signed(yr[XY_W:16]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      it_q    <= '0;
      done_q  <= 1'b0;
      cos_q   <= '0;
      sin_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (start_i) begin
            state_q <= C_LOAD;
          end
        end
        C_LOAD: begin
          it_q    <= '0;
          state_q <= C_ITER;
        end
        C_ITER: begin
          it_q <= it_q + IT_W'(1);
          if (it_q == IT_W'(CORDIC_ITERATIONS - 1)) begin
            state_q <= C_ROUND;
          end
        end
        C_ROUND: begin
          done_q  <= 1'b1;
          cos_q   <= flip_q ? -TRIG_W'(rc) : TRIG_W'(rc);
          sin_q   <= flip_q ? -TRIG_W'(rs) : TRIG_W'(rs);
          state_q <= C_IDLE;
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      C_IDLE: begin
        if (start_i) begin
          prod_q <= PROD_W'(len_i) * PROD_W'(GAIN_Q30);
          z_q    <= $signed({a_fold, 16'd0});
          flip_q <= flip_d;
        end
      end
      C_LOAD: begin
        x_q <= $signed(XY_W'(prod_q[PROD_W-1:14]));
        y_q <= '0;
      end
      C_ITER: begin
        if (!z_q[Z_W-1]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + at;
        end
      end
      default: ;
    endcase
  end

  assign res_o.done = done_q;
  assign res_o.cos  = cos_q;
  assign res_o.sin  = sin_q;

endmodule

/* hdl/prr_arm_forward_kinematics.sv */
// ---------------------------------------------------------------------------
// prr_arm_forward_kinematics
// Jog engine for a slider plus two rotary links; one pose result per command.
// ---------------------------------------------------------------------------
// Each command yields one pose transfer. A slide goes straight from its
// transfer to the output state. A wrist jog runs the shared CORDIC once; a
// shoulder jog runs it twice, elbow then brush. The single iterative CORDIC
// performs one micro-rotation per cycle; a receiver that still holds the
// previous result stalls the output state. A new command is taken only once
// the previous one has left the sequencer; the pose register lets that happen
// while the last result still waits.
`include "prr_arm_forward_kinematics_macros.svh"

module prr_arm_forward_kinematics import prr_fk_pkg::*; #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int POS_WIDTH         = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  prr_fk_jog_if.sink        jog_i,
  prr_fk_pose_if.source     pose_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int PW = POS_WIDTH;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] POS_MAX = SW'((64'sd1 <<< (PW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] POS_MIN = -POS_MAX - SW'(1);

  typedef enum logic [2:0] {
    S_IDLE, S_ROT1_GO, S_ROT1_WAIT, S_ROT2_GO, S_ROT2_WAIT, S_OUT
  } state_e;

  function automatic logic signed [PW-1:0] sat_pos(input logic signed [SW-1:0] v);
    logic signed [PW-1:0] r;
    if (v > POS_MAX) begin
      r = POS_MAX[PW-1:0];
    end else if (v < POS_MIN) begin
      r = POS_MIN[PW-1:0];
    end else begin
      r = v[PW-1:0];
    end
    return r;
  endfunction

  function automatic logic [ANG_W-1:0] wrap_add(input logic [ANG_W-1:0] ang,
                                                input logic signed [AMT_W-1:0] amt);
    logic signed [ANG_W+1:0] s;
    s = $signed({2'b00, ang}) + (ANG_W+2)'(amt);
    if (s < 0) begin
      s = s + $signed({2'b00, FULL_TURN});
    end else if (s >= $signed({2'b00, FULL_TURN})) begin
      s = s - $signed({2'b00, FULL_TURN});
    end
    return s[ANG_W-1:0];
  endfunction

  cfg_t   cfg;
  trig_t  trig;
  state_e state_q;

  logic signed [PW-1:0] base_x_q, elbow_px_q, elbow_py_q, tip_px_q, tip_py_q;
  logic [ANG_W-1:0]     angle_one_q, angle_two_q;
  logic                 out_valid_q;
  logic                 cordic_start;
  logic [LEN_W-1:0]     cordic_len;
  logic [ANG_W-1:0]     cordic_ang;
  logic                 in_xfer;
  logic                 out_load;

  prr_fk_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  prr_fk_cordic #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .len_i   (cordic_len),
    .ang_i   (cordic_ang),
    .res_o   (trig)
  );

  assign jog_i.ready  = (state_q == S_IDLE);
  assign in_xfer      = jog_i.valid && jog_i.ready;
  assign cordic_start = (state_q == S_ROT1_GO) || (state_q == S_ROT2_GO);
  assign cordic_len   = (state_q == S_ROT1_GO) ? cfg.link1 : cfg.link2;
  assign cordic_ang   = (state_q == S_ROT1_GO) ? angle_one_q : angle_two_q;
  assign out_load     = (state_q == S_OUT) && (!out_valid_q || pose_o.ready);
  assign pose_o.valid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q               <= S_IDLE;
      out_valid_q           <= 1'b0;
      base_x_q              <= '0;
      angle_one_q           <= QUARTER_TURN;
      angle_two_q           <= QUARTER_TURN;
      elbow_px_q            <= '0;
      elbow_py_q            <= PW'(4000);
      tip_px_q              <= '0;
      tip_py_q              <= PW'(5200);
      pose_o.base_pos_x     <= '0;
      pose_o.shoulder_angle <= '0;
      pose_o.link2_angle    <= '0;
      pose_o.elbow_x        <= '0;
      pose_o.elbow_y        <= '0;
      pose_o.brush_x        <= '0;
      pose_o.brush_y        <= '0;
    end else begin
      if (out_load) begin
        out_valid_q           <= 1'b1;
        pose_o.base_pos_x     <= base_x_q;
        pose_o.shoulder_angle <= angle_one_q;
        pose_o.link2_angle    <= angle_two_q;
        pose_o.elbow_x        <= elbow_px_q;
        pose_o.elbow_y        <= elbow_py_q;
        pose_o.brush_x        <= tip_px_q;
        pose_o.brush_y        <= tip_py_q;
      end else if (pose_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            unique case (jog_i.cmd)
              CMD_SLIDE: begin
                base_x_q   <= sat_pos(SW'(base_x_q) + SW'(jog_i.amount));
                elbow_px_q <= sat_pos(SW'(elbow_px_q) + SW'(jog_i.amount));
                tip_px_q   <= sat_pos(SW'(tip_px_q) + SW'(jog_i.amount));
                state_q    <= S_OUT;
              end
              CMD_SHOULDER: begin
                angle_one_q <= wrap_add(angle_one_q, jog_i.amount);
                angle_two_q <= wrap_add(angle_two_q, jog_i.amount);
                state_q     <= S_ROT1_GO;
              end
              CMD_WRIST: begin
                angle_two_q <= wrap_add(angle_two_q, jog_i.amount);
                state_q     <= S_ROT2_GO;
              end
              default: state_q <= S_OUT;
            endcase
          end
        end
        S_ROT1_GO: state_q <= S_ROT1_WAIT;
        S_ROT1_WAIT: begin
          if (trig.done) begin
            elbow_px_q <= sat_pos(SW'(base_x_q) + SW'(trig.cos));
            elbow_py_q <= sat_pos($signed(SW'(cfg.shoulder)) + SW'(trig.sin));
            state_q    <= S_ROT2_GO;
          end
        end
        S_ROT2_GO: state_q <= S_ROT2_WAIT;
        S_ROT2_WAIT: begin
          if (trig.done) begin
            tip_px_q <= sat_pos(SW'(elbow_px_q) + SW'(trig.cos));
            tip_py_q <= sat_pos(SW'(elbow_py_q) + SW'(trig.sin));
            state_q  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `PRR_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !jog_i.ready)
  `PRR_ASSERT_IMPL(a_angle_wrapped, 1'b1, (angle_one_q < FULL_TURN) && (angle_two_q < FULL_TURN))
  `PRR_ASSERT_IMPL(a_done_in_wait, trig.done, (state_q == S_ROT1_WAIT) || (state_q == S_ROT2_WAIT))

endmodule
